FILE: hw/rtl/gost_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gost_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int NUM_KEYS   = 8;
    localparam int KEY_IDX_W  = 3;
    localparam int RND_IDX_W  = 5;
    localparam int ROT_LEFT   = 11;
    localparam int ENC_PHASE  = 24;  // first round of the reversed key order on encrypt
    localparam int DEC_PHASE  = 8;   // first round of the reversed key order on decrypt

    typedef logic [31:0]                   t_word;
    typedef logic [NUM_KEYS-1:0][31:0]     t_keys;
    typedef logic [KEY_IDX_W-1:0]          t_key_idx;
    typedef logic [RND_IDX_W-1:0]          t_rnd_idx;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    // Control that travels alongside the data through every stage.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

    // Row 0 substitutes the top nibble of the sum, row 7 the bottom one.
    localparam logic [3:0] SBOX [8][16] = '{
        '{4'h1, 4'h3, 4'hA, 4'h9, 4'h5, 4'hB, 4'h4, 4'hF,
          4'h8, 4'h6, 4'h7, 4'hE, 4'hD, 4'h0, 4'h2, 4'hC},
        '{4'hD, 4'hE, 4'h4, 4'h1, 4'h7, 4'h0, 4'h5, 4'hA,
          4'h3, 4'hC, 4'h8, 4'hF, 4'h6, 4'h2, 4'h9, 4'hB},
        '{4'h7, 4'h6, 4'h2, 4'h4, 4'hD, 4'h9, 4'hF, 4'h0,
          4'hA, 4'h1, 4'h5, 4'hB, 4'h8, 4'hE, 4'hC, 4'h3},
        '{4'h7, 4'h6, 4'h4, 4'hB, 4'h9, 4'hC, 4'h2, 4'hA,
          4'h1, 4'h8, 4'h0, 4'hE, 4'hF, 4'hD, 4'h3, 4'h5},
        '{4'h4, 4'hA, 4'h7, 4'hC, 4'h0, 4'hF, 4'h2, 4'h8,
          4'hE, 4'h1, 4'h6, 4'h5, 4'hD, 4'hB, 4'h9, 4'h3},
        '{4'h7, 4'hF, 4'hC, 4'hE, 4'h9, 4'h4, 4'h1, 4'h0,
          4'h3, 4'hB, 4'h5, 4'h2, 4'h6, 4'hA, 4'h8, 4'hD},
        '{4'h5, 4'hF, 4'h4, 4'h0, 4'h2, 4'hD, 4'hB, 4'h9,
          4'h1, 4'h7, 4'h6, 4'h3, 4'hC, 4'hE, 4'hA, 4'h8},
        '{4'hA, 4'h4, 4'h5, 4'h6, 4'h8, 4'h1, 4'h3, 4'h7,
          4'hD, 4'hC, 4'hE, 4'h0, 4'h9, 4'h2, 4'hB, 4'hF}
    };

    // Round function: key add, nibble substitution, rotate left.
    function automatic t_word round_fn(input t_word half, input t_word key);
        t_word sum;
        t_word sub;
        sum = half + key;
        for (int n = 0; n < 8; n++) begin
            sub[4*n +: 4] = SBOX[7-n][sum[4*n +: 4]];
        end
        return {sub[31-ROT_LEFT:0], sub[31:32-ROT_LEFT]};
    endfunction

    // Key word used by a given round for a given direction.
    function automatic t_key_idx key_sel(input t_op op, input t_rnd_idx rnd);
        t_key_idx lo;
        logic     fwd;
        lo = rnd[KEY_IDX_W-1:0];
        if (op == OP_DECRYPT) begin
            fwd = (rnd < t_rnd_idx'(DEC_PHASE));
        end else begin
            fwd = (rnd < t_rnd_idx'(ENC_PHASE));
        end
        return fwd ? lo : ~lo;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gost_keys.sv
`timescale 1ns / 1ps
`default_nettype none

module gost_keys (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire gost_pkg::t_key_idx    i_cfg_index,
    input  wire gost_pkg::t_word       i_cfg_data,
    output gost_pkg::t_keys            o_keys
);

    gost_pkg::t_keys r_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else if (i_cfg_we) begin
            r_keys[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_keys = r_keys;

endmodule

`default_nettype wire

FILE: hw/rtl/gost_rnd.sv
`timescale 1ns / 1ps
`default_nettype none

// One Feistel round with its pipeline register. The half in x feeds the
// round function; the halves swap on every round.
module gost_rnd (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire gost_pkg::t_ctl    i_ctl,
    input  wire gost_pkg::t_word   i_x,
    input  wire gost_pkg::t_word   i_y,
    input  wire gost_pkg::t_word   i_key,
    input  wire                    i_ready,
    output logic                   o_ready,
    output gost_pkg::t_ctl         o_ctl,
    output gost_pkg::t_word        o_x,
    output gost_pkg::t_word        o_y
);

    logic              r_valid;
    gost_pkg::t_op     r_op;
    gost_pkg::t_word   r_x;
    gost_pkg::t_word   r_y;
    gost_pkg::t_word   n_x;

    // The stage can take a new item when it is empty or its item moves on.
    assign o_ready = !r_valid || i_ready;
    assign n_x     = i_y ^ gost_pkg::round_fn(i_x, i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_op <= i_ctl.op;
            r_x  <= n_x;
            r_y  <= i_x;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.op    = r_op;
    assign o_x         = r_x;
    assign o_y         = r_y;

endmodule

`default_nettype wire

FILE: hw/rtl/gost_block_cipher_64.sv
`timescale 1ns / 1ps
`default_nettype none

// GOST 28147-89 block cipher, 64-bit blocks, fixed CryptoPro S-boxes.
//
// Input channel (i_valid / o_ready) carries one item: i_operation selects
// encrypt (0) or decrypt (1) and i_block_in is the block, low word first.
// Output channel (o_valid / i_ready) returns one item per input item,
// o_block_out, in the order the items were accepted.
// The write port (i_cfg_we, i_cfg_index, i_cfg_data) loads the eight 32-bit
// key words; the user must load them while no item is in flight (unenforced).
//
// Each of the 32 rounds has its own pipeline stage, so a new item can enter
// every cycle while the receiver keeps taking results; the sustained rate is
// one item per cycle without output stalls, set by the one-round stage depth.
// The last stage's register is the output register.
//
// Reset (synchronous, active low) empties all stages and clears the keys.
// When the receiver stalls, stages fill up behind the waiting result; each
// stage holds its item until the next one frees up, so nothing is lost or
// repeated. o_ready drops only when all 32 stages hold items.
module gost_block_cipher_64 (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire                       i_operation,
    input  wire [63:0]                i_block_in,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic [63:0]               o_block_out,
    input  wire                       i_cfg_we,
    input  wire [2:0]                 i_cfg_index,
    input  wire [31:0]                i_cfg_data
);

    localparam int N = gost_pkg::NUM_ROUNDS;

    gost_pkg::t_keys  keys;
    gost_pkg::t_ctl   ctl   [N+1];
    gost_pkg::t_word  x     [N+1];
    gost_pkg::t_word  y     [N+1];
    logic [N:0]       rdy;
    logic [N-1:0]     stage_valid;

    gost_keys u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_keys      (keys)
    );

    // Entry point: the first half (low word) feeds the first round.
    assign ctl[0].valid = i_valid;
    assign ctl[0].op    = gost_pkg::t_op'(i_operation);
    assign x[0]         = i_block_in[31:0];
    assign y[0]         = i_block_in[63:32];
    assign rdy[N]       = i_ready;

    for (genvar g = 0; g < N; g++) begin : g_round
        gost_rnd u_rnd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[g]),
            .i_x     (x[g]),
            .i_y     (y[g]),
            .i_key   (keys[gost_pkg::key_sel(ctl[g].op, gost_pkg::t_rnd_idx'(g))]),
            .i_ready (rdy[g+1]),
            .o_ready (rdy[g]),
            .o_ctl   (ctl[g+1]),
            .o_x     (x[g+1]),
            .o_y     (y[g+1])
        );
        assign stage_valid[g] = ctl[g+1].valid;
    end

    assign o_ready = rdy[0];
    assign o_valid = ctl[N].valid;

    // After the last round x holds the final n1 and y the final n2.
    assign o_block_out = {x[N], y[N]};

    // The pipeline only pushes back when every stage is occupied.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (stage_valid == '1))
        else $error("input stalled while a stage was empty");

    // A ready receiver always frees the whole pipeline.
    a_ready_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("receiver ready but input blocked");

    // Reset leaves every stage empty.
    a_reset_empties: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (stage_valid == '0))
        else $error("stage valid after reset");

endmodule

`default_nettype wire

FILE: test/gost_cipher_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the key write port of the GOST cipher, works out the
// expected output block of every accepted item and compares it with what comes out.
module gost_cipher_checker
    import gost_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  wire        i_ready_in,
    input  wire        i_operation,
    input  wire [63:0] i_block_in,
    input  wire        i_valid_out,
    input  wire        i_ready,
    input  wire [63:0] i_block_out,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_index,
    input  wire [31:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending
);

    localparam int ROTATE = 11;

    // Row r substitutes nibble 7-r of the sum.
    localparam logic [3:0] SUBST [8][16] = '{
        '{4'h1, 4'h3, 4'hA, 4'h9, 4'h5, 4'hB, 4'h4, 4'hF,
          4'h8, 4'h6, 4'h7, 4'hE, 4'hD, 4'h0, 4'h2, 4'hC},
        '{4'hD, 4'hE, 4'h4, 4'h1, 4'h7, 4'h0, 4'h5, 4'hA,
          4'h3, 4'hC, 4'h8, 4'hF, 4'h6, 4'h2, 4'h9, 4'hB},
        '{4'h7, 4'h6, 4'h2, 4'h4, 4'hD, 4'h9, 4'hF, 4'h0,
          4'hA, 4'h1, 4'h5, 4'hB, 4'h8, 4'hE, 4'hC, 4'h3},
        '{4'h7, 4'h6, 4'h4, 4'hB, 4'h9, 4'hC, 4'h2, 4'hA,
          4'h1, 4'h8, 4'h0, 4'hE, 4'hF, 4'hD, 4'h3, 4'h5},
        '{4'h4, 4'hA, 4'h7, 4'hC, 4'h0, 4'hF, 4'h2, 4'h8,
          4'hE, 4'h1, 4'h6, 4'h5, 4'hD, 4'hB, 4'h9, 4'h3},
        '{4'h7, 4'hF, 4'hC, 4'hE, 4'h9, 4'h4, 4'h1, 4'h0,
          4'h3, 4'hB, 4'h5, 4'h2, 4'h6, 4'hA, 4'h8, 4'hD},
        '{4'h5, 4'hF, 4'h4, 4'h0, 4'h2, 4'hD, 4'hB, 4'h9,
          4'h1, 4'h7, 4'h6, 4'h3, 4'hC, 4'hE, 4'hA, 4'h8},
        '{4'hA, 4'h4, 4'h5, 4'h6, 4'h8, 4'h1, 4'h3, 4'h7,
          4'hD, 4'hC, 4'hE, 4'h0, 4'h9, 4'h2, 4'hB, 4'hF}
    };

    typedef struct packed {
        t_op         op;
        logic [63:0] block_in;
        logic [63:0] block_out;
    } t_cipher_job;

    t_word       key_copy [NUM_KEYS];
    t_cipher_job pending_blocks [$];
    int          errors = 0;

    function automatic t_word mix_half(input t_word half, input t_word key);
        t_word sum;
        t_word sub;
        sum = half + key;
        for (int n = 0; n < 8; n++)
            sub[4*n +: 4] = SUBST[7-n][sum[4*n +: 4]];
        return (sub << ROTATE) | (sub >> (32 - ROTATE));
    endfunction

    // Full 32-round network; the halves leave swapped.
    function automatic logic [63:0] gost_crypt(input t_op op, input logic [63:0] blk);
        t_word n1;
        t_word n2;
        int    idx;
        n1 = blk[31:0];
        n2 = blk[63:32];
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            if (op == OP_DECRYPT)
                idx = (r < 8) ? (r % 8) : 7 - (r % 8);
            else
                idx = (r < 24) ? (r % 8) : 7 - (r % 8);
            if (r % 2 == 0)
                n2 ^= mix_half(n1, key_copy[idx]);
            else
                n1 ^= mix_half(n2, key_copy[idx]);
        end
        return {n1, n2};
    endfunction

    always @(posedge i_clk) begin : watch
        t_cipher_job job;
        if (!i_rst_n) begin
            foreach (key_copy[k])
                key_copy[k] = '0;
            pending_blocks.delete();
        end else begin
            if (i_cfg_we)
                key_copy[i_cfg_index] = i_cfg_data;
            if (i_valid_out && i_ready) begin
                if (pending_blocks.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, i_block_out);
                end else begin
                    job = pending_blocks.pop_front();
                    if (i_block_out !== job.block_out) begin
                        errors++;
                        $display("%0t: block_out mismatch (%s of %h): expected %h, actual %h",
                                 $time, job.op.name(), job.block_in, job.block_out,
                                 i_block_out);
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                job.op        = t_op'(i_operation);
                job.block_in  = i_block_in;
                job.block_out = gost_crypt(job.op, i_block_in);
                pending_blocks.push_back(job);
            end
        end
        o_pending <= pending_blocks.size();
        o_errors  <= errors;
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

// Testbench for the pipelined GOST 28147-89 block cipher.
// The top only produces stimulus: key loads through the write port, input items
// and the receiver's ready pattern. The checker beside the block predicts every
// output block and counts mismatches; the top turns that count into the verdict.
module tb;
    import gost_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_operation = 1'b0;
    logic [63:0] i_block_in  = '0;
    logic        i_ready     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        o_ready;
    logic        o_valid;
    logic [63:0] o_block_out;
    int          errors;
    int          pending;

    // Idle rates in percent for the two sides, and a request for a long
    // receiver hold-off that the receiver process counts out by itself.
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    always #1 i_clk = ~i_clk;

    gost_block_cipher_64 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_block_in  (i_block_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_block_out (o_block_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    gost_cipher_checker gost_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_ready_in  (o_ready),
        .i_operation (i_operation),
        .i_block_in  (i_block_in),
        .i_valid_out (o_valid),
        .i_ready     (i_ready),
        .i_block_out (o_block_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Receiver. Ready is redrawn every cycle from the current idle rate. A hold-off
    // request keeps ready low for a long stretch so that all 32 round stages fill
    // up and the block has to drop o_ready while the sender keeps offering items.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 150;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Offers one item. Idle cycles, if any, come before valid rises; once raised,
    // valid and the payload stay put until the edge at which o_ready was high.
    // Valid is not lowered here, so back-to-back items keep it high without a
    // second assignment in the same step.
    task automatic send_block(input t_op op, input logic [63:0] blk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_block_in  <= blk;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stops offering items and waits until every expected block has come out.
    // The extra cycles cover the pipeline depth before the block is reconfigured
    // or the run ends.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (NUM_ROUNDS + 8) @(posedge i_clk);
    endtask

    // Keys are only written once the pipeline is empty, one word per cycle.
    task automatic load_keys(input t_word keys [NUM_KEYS]);
        drain();
        for (int k = 0; k < NUM_KEYS; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_key_idx'(k);
            i_cfg_data  <= keys[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random_keys();
        t_word keys [NUM_KEYS];
        foreach (keys[k])
            keys[k] = $urandom;
        load_keys(keys);
    endtask

    // Mostly random blocks, with the all-zero and all-one blocks mixed in now and then.
    task automatic send_random_blocks(input int count);
        logic [63:0] blk;
        repeat (count) begin
            case ($urandom_range(15))
                0:       blk = '0;
                1:       blk = '1;
                default: blk = {$urandom, $urandom};
            endcase
            send_block(t_op'($urandom_range(1)), blk);
        end
    endtask

    initial begin
        t_word       keys [NUM_KEYS];
        logic [63:0] corner [7];

        corner = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                   64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_FFFF_FFFF,
                   64'hFFFF_FFFF_0000_0000, 64'h8000_0000_0000_0001};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. First with the all-zero keys left by reset.
        send_block(OP_ENCRYPT, '0);
        send_block(OP_ENCRYPT, '1);
        send_block(OP_DECRYPT, '0);
        send_block(OP_DECRYPT, '1);

        // All-one keys make each key addition carry unless the half is zero; corner blocks both ways.
        foreach (keys[k])
            keys[k] = '1;
        load_keys(keys);
        foreach (corner[c]) begin
            send_block(OP_ENCRYPT, corner[c]);
            send_block(OP_DECRYPT, corner[c]);
        end

        // Alternating key words show whether the right word is picked per round.
        foreach (keys[k])
            keys[k] = (k % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF;
        load_keys(keys);
        send_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
        send_block(OP_DECRYPT, 64'h0123_4567_89AB_CDEF);

        // Random part, first with a slow receiver, then with a slow sender.
        src_idle_pct = 26;
        dst_idle_pct = 69;
        load_random_keys();
        send_random_blocks(150);

        src_idle_pct = 69;
        dst_idle_pct = 26;
        load_random_keys();
        send_random_blocks(150);

        // Neither side idles. The receiver starts with a long hold-off while the
        // sender streams items back to back, so the pipeline fills and stalls.
        src_idle_pct = 0;
        dst_idle_pct = 0;
        load_random_keys();
        hold_req = 1'b1;
        send_random_blocks(150);

        drain();
        if (errors == 0 && pending == 0) begin
            $display("gost_block_cipher_64 test passed");
        end else begin
            $display("gost_block_cipher_64 test failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #400000;
        $display("gost_block_cipher_64 test failed");
        $finish;
    end

endmodule
